// ----- hdl/scg_pkg.sv -----
// ----------------------------------------------------------------------------
// scg_pkg
// Shared types and constants of the stream chunk grouper: register map,
// tail modes, item kinds and the configuration bundle.
// ----------------------------------------------------------------------------
package scg_pkg;

  localparam int MAX_GROUP_DEF  = 64;
  localparam int ELEM_WIDTH_DEF = 32;

  localparam int DATA_W   = 32;
  localparam int POS_W    = 6;
  localparam int GSIZE_W  = 7;
  localparam int MODE_W   = 2;
  localparam int PADDR_W  = 4;

  localparam logic [1:0] REG_GROUP_SIZE = 2'd0;
  localparam logic [1:0] REG_TAIL_MODE  = 2'd1;
  localparam logic [1:0] REG_FILL_VALUE = 2'd2;

  localparam logic [MODE_W-1:0] TAIL_SHORT = 2'd0;
  localparam logic [MODE_W-1:0] TAIL_PAD   = 2'd1;
  localparam logic [MODE_W-1:0] TAIL_DROP  = 2'd2;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic [GSIZE_W-1:0] group_size;
    logic [MODE_W-1:0]  tail_mode;
    logic [DATA_W-1:0]  fill_value;
  } cfg_t;

endpackage

// ----- hdl/scg_regs.sv -----
// ----------------------------------------------------------------------------
// scg_regs
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module scg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [scg_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output scg_pkg::cfg_t               cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.group_size <= scg_pkg::GSIZE_W'(1);
      cfg.tail_mode  <= scg_pkg::TAIL_SHORT;
      cfg.fill_value <= '0;
    end else if (wr) begin
      unique case (paddr[3:2])
        scg_pkg::REG_GROUP_SIZE: cfg.group_size <= pwdata[scg_pkg::GSIZE_W-1:0];
        scg_pkg::REG_TAIL_MODE:  cfg.tail_mode  <= pwdata[scg_pkg::MODE_W-1:0];
        scg_pkg::REG_FILL_VALUE: cfg.fill_value <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      scg_pkg::REG_GROUP_SIZE: prdata = 32'(cfg.group_size);
      scg_pkg::REG_TAIL_MODE:  prdata = 32'(cfg.tail_mode);
      scg_pkg::REG_FILL_VALUE: prdata = cfg.fill_value;
      default:                 prdata = '0;
    endcase
  end

endmodule

// ----- hdl/scg_front.sv -----
// ----------------------------------------------------------------------------
// scg_front
// Accepts items, writes data elements into the current group bank and
// posts a drain job when a group is complete or a tail is to be emitted.
// ----------------------------------------------------------------------------
module scg_front #(
  parameter int MAX_GROUP  = scg_pkg::MAX_GROUP_DEF,
  parameter int ELEM_WIDTH = scg_pkg::ELEM_WIDTH_DEF,
  localparam int CW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1,
  localparam int TW = $clog2(MAX_GROUP + 1),
  localparam int JW = 1 + 2 * TW
) (
  input  logic                      clk,
  input  logic                      rst,
  input  scg_pkg::cfg_t             cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      kind,
  input  logic [scg_pkg::DATA_W-1:0] value,
  output logic                      wr_en,
  output logic [CW:0]               wr_addr,
  output logic [ELEM_WIDTH-1:0]     wr_data,
  output logic                      job_push,
  output logic [JW-1:0]             job_data,
  input  logic                      job_full
);

  logic          bank;
  logic          bank_next;
  logic [CW-1:0] fill;
  logic [CW-1:0] fill_next;
  logic [TW-1:0] fill_ext;
  logic [TW-1:0] cnt1;
  logic [TW-1:0] size;
  logic [TW-1:0] job_cnt;
  logic [TW-1:0] job_total;
  logic          accept;

  assign in_ready = !job_full;
  assign accept   = in_valid && in_ready;
  assign fill_ext = TW'(fill);
  assign cnt1     = fill_ext + TW'(1);
  assign wr_addr  = {bank, fill};
  assign wr_data  = ELEM_WIDTH'(value);
  assign job_data = {bank, job_cnt, job_total};

  always_comb begin
    priority if (cfg.group_size == '0) begin
      size = TW'(1);
    end else if (cfg.group_size > scg_pkg::GSIZE_W'(MAX_GROUP)) begin
      size = TW'(MAX_GROUP);
    end else begin
      size = TW'(cfg.group_size);
    end
  end

  always_comb begin
    wr_en     = 1'b0;
    job_push  = 1'b0;
    job_cnt   = fill_ext;
    job_total = fill_ext;
    fill_next = fill;
    if (accept) begin
      if (kind == scg_pkg::KIND_DATA) begin
        wr_en = 1'b1;
        if (cnt1 >= size) begin
          job_push  = 1'b1;
          job_cnt   = cnt1;
          job_total = cnt1;
          fill_next = '0;
        end else begin
          fill_next = CW'(cnt1);
        end
      end else begin
        fill_next = '0;
        if (fill != '0) begin
          priority if (fill_ext >= size) begin
            job_push = 1'b1;
          end else if (cfg.tail_mode == scg_pkg::TAIL_SHORT) begin
            job_push = 1'b1;
          end else if (cfg.tail_mode == scg_pkg::TAIL_PAD) begin
            job_push  = 1'b1;
            job_total = size;
          end else begin
            job_push = 1'b0;
          end
        end
      end
    end
    bank_next = job_push ? !bank : bank;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank <= 1'b0;
      fill <= '0;
    end else begin
      bank <= bank_next;
      fill <= fill_next;
    end
  end

endmodule

// ----- hdl/scg_job_fifo.sv -----
// ----------------------------------------------------------------------------
// scg_job_fifo
// Two-entry job queue between the front and the drain, one entry per
// group bank.
// ----------------------------------------------------------------------------
module scg_job_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] head,
  output logic         full,
  output logic         empty
);

  logic [W-1:0] slots [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   count;

  assign head  = slots[rptr];
  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hdl/scg_back.sv -----
// ----------------------------------------------------------------------------
// scg_back
// Group memory and drain: reads the queued group one element per cycle unless
// stalled, substitutes padding past the stored count, feeds the output register.
// ----------------------------------------------------------------------------
module scg_back #(
  parameter int MAX_GROUP  = scg_pkg::MAX_GROUP_DEF,
  parameter int ELEM_WIDTH = scg_pkg::ELEM_WIDTH_DEF,
  localparam int CW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1,
  localparam int TW = $clog2(MAX_GROUP + 1),
  localparam int JW = 1 + 2 * TW
) (
  input  logic                       clk,
  input  logic                       rst,
  input  scg_pkg::cfg_t              cfg,
  input  logic                       wr_en,
  input  logic [CW:0]                wr_addr,
  input  logic [ELEM_WIDTH-1:0]      wr_data,
  input  logic [JW-1:0]              job_head,
  input  logic                       job_empty,
  output logic                       job_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [scg_pkg::DATA_W-1:0] element,
  output logic [scg_pkg::POS_W-1:0]  position,
  output logic                       group_last
);

  logic [ELEM_WIDTH-1:0] mem [2 ** (CW + 1)];
  logic [ELEM_WIDTH-1:0] rdata;

  logic          head_bank;
  logic [TW-1:0] head_cnt;
  logic [TW-1:0] head_total;
  logic [CW-1:0] idx;
  logic [TW-1:0] idx_ext;
  logic          idx_last;
  logic          issue;
  logic          move;

  logic          s1_valid;
  logic          s1_pad;
  logic [CW-1:0] s1_pos;
  logic          s1_last;

  logic [scg_pkg::DATA_W-1:0] pad;

  assign head_bank  = job_head[JW-1];
  assign head_cnt   = job_head[2*TW-1:TW];
  assign head_total = job_head[TW-1:0];
  assign idx_ext    = TW'(idx);
  assign idx_last   = (idx_ext + TW'(1) == head_total);
  assign move       = s1_valid && (!out_valid || out_ready);
  assign issue      = !job_empty && (!s1_valid || move);
  assign job_pop    = issue && idx_last;
  assign pad        = scg_pkg::DATA_W'(ELEM_WIDTH'(cfg.fill_value));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rdata <= mem[{head_bank, idx}];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_pad  <= (idx_ext >= head_cnt);
      s1_pos  <= idx;
      s1_last <= idx_last;
    end
    if (move) begin
      element    <= s1_pad ? pad : scg_pkg::DATA_W'(rdata);
      position   <= scg_pkg::POS_W'(s1_pos);
      group_last <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        idx <= idx_last ? '0 : idx + CW'(1);
      end
      if (issue) begin
        s1_valid <= 1'b1;
      end else if (move) begin
        s1_valid <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/stream_chunk_grouper.sv -----
// ----------------------------------------------------------------------------
// stream_chunk_grouper
// Collects data items into groups of group_size and emits each group element
// by element, with the last element marked and a configurable tail policy.
// ----------------------------------------------------------------------------
// The block takes one item per cycle while input is not held off and delivers
// one group element per cycle while the output is not stalled. A data item is
// written into one of two group banks; a complete group, or a tail that is
// emitted short or padded, is handed to the drain, which reads the bank through
// a single memory read port into a read stage ahead of the output register.
// While both banks wait to be drained, input is held off; otherwise items keep
// flowing while the previous group drains. Configuration is to be written over
// the APB-style port only while the block is idle; the block does not enforce it.
module stream_chunk_grouper #(
  parameter int MAX_GROUP  = scg_pkg::MAX_GROUP_DEF,
  parameter int ELEM_WIDTH = scg_pkg::ELEM_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [scg_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        kind,
  input  logic [scg_pkg::DATA_W-1:0]  value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [scg_pkg::DATA_W-1:0]  element,
  output logic [scg_pkg::POS_W-1:0]   position,
  output logic                        group_last
);

  localparam int CW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int TW = $clog2(MAX_GROUP + 1);
  localparam int JW = 1 + 2 * TW;

  scg_pkg::cfg_t         cfg;
  logic                  wr_en;
  logic [CW:0]           wr_addr;
  logic [ELEM_WIDTH-1:0] wr_data;
  logic                  job_push;
  logic [JW-1:0]         job_data;
  logic                  job_pop;
  logic [JW-1:0]         job_head;
  logic                  job_full;
  logic                  job_empty;

  scg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  scg_front #(
    .MAX_GROUP  (MAX_GROUP),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .value    (value),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .job_push (job_push),
    .job_data (job_data),
    .job_full (job_full)
  );

  scg_job_fifo #(
    .W (JW)
  ) u_jobs (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (job_data),
    .pop       (job_pop),
    .head      (job_head),
    .full      (job_full),
    .empty     (job_empty)
  );

  scg_back #(
    .MAX_GROUP  (MAX_GROUP),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .job_head   (job_head),
    .job_empty  (job_empty),
    .job_pop    (job_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .element    (element),
    .position   (position),
    .group_last (group_last)
  );

  // The front never writes into the bank that the drain is reading.
  a_bank_apart: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !job_empty) |-> (wr_addr[CW] != job_head[JW-1]))
    else $error("group bank written while it is being drained");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    job_full |-> !job_push)
    else $error("job posted into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> !job_empty)
    else $error("job retired from an empty queue");

endmodule

// ----- tb/tb_stream_chunk_grouper.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stream_chunk_grouper
// Self-checking testbench for the stream chunk grouper. A scoreboard class
// tracks the group buffer and the registers, expands every accepted item
// into the group elements it releases, and compares them in order with the
// elements leaving the block. Directed items cover the register extremes and
// the tail policies, then random phases vary the settings and the idling.
// ----------------------------------------------------------------------------
module tb_stream_chunk_grouper;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS = 50;
  localparam int SHOWN_ERRORS = 100;
  localparam logic [1:0] REG_UNMAPPED = 2'd3;
  localparam logic [scg_pkg::MODE_W-1:0] TAIL_UNUSED = 2'd3;

  typedef struct {
    logic [scg_pkg::DATA_W-1:0] element;
    logic [scg_pkg::POS_W-1:0]  position;
    logic                       group_last;
  } grouped_elem_t;

  class chunk_scoreboard;
    logic [scg_pkg::DATA_W-1:0]  group_mem [scg_pkg::MAX_GROUP_DEF];
    int unsigned                 held;
    logic [scg_pkg::GSIZE_W-1:0] group_size;
    logic [scg_pkg::MODE_W-1:0]  tail_mode;
    logic [scg_pkg::DATA_W-1:0]  fill_value;
    grouped_elem_t               pending_elems [$];
    int                          errors;

    function new();
      held = 0;
      group_size = 1;
      tail_mode = scg_pkg::TAIL_SHORT;
      fill_value = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] index, logic [31:0] data);
      case (index)
        scg_pkg::REG_GROUP_SIZE: group_size = data[scg_pkg::GSIZE_W-1:0];
        scg_pkg::REG_TAIL_MODE:  tail_mode = data[scg_pkg::MODE_W-1:0];
        scg_pkg::REG_FILL_VALUE: fill_value = data[scg_pkg::DATA_W-1:0];
        default: ;
      endcase
    endfunction

    function void release_group(int unsigned cnt, int unsigned total);
      grouped_elem_t g;
      for (int unsigned i = 0; i < total; i++) begin
        g.element = (i < cnt) ? group_mem[i] : fill_value;
        g.position = i[scg_pkg::POS_W-1:0];
        g.group_last = (i + 1 == total);
        pending_elems.push_back(g);
      end
    endfunction

    function void accept_item(logic k, logic [scg_pkg::DATA_W-1:0] v);
      int unsigned eff;
      int unsigned cnt;
      eff = (group_size == 0) ? 1 :
            (group_size > scg_pkg::MAX_GROUP_DEF) ? scg_pkg::MAX_GROUP_DEF : group_size;
      cnt = held;
      if (k == scg_pkg::KIND_DATA) begin
        if (cnt >= scg_pkg::MAX_GROUP_DEF) cnt = scg_pkg::MAX_GROUP_DEF - 1;
        group_mem[cnt] = v;
        cnt++;
        if (cnt >= eff) begin
          release_group(cnt, cnt);
          held = 0;
        end else begin
          held = cnt;
        end
        return;
      end
      held = 0;
      if (cnt == 0) return;
      if (cnt >= eff || tail_mode == scg_pkg::TAIL_SHORT) release_group(cnt, cnt);
      else if (tail_mode == scg_pkg::TAIL_PAD) release_group(cnt, eff);
    endfunction

    function void check_element(logic [scg_pkg::DATA_W-1:0] e,
                                logic [scg_pkg::POS_W-1:0] p, logic l);
      grouped_elem_t want;
      if (pending_elems.size() == 0) begin
        errors++;
        if (errors <= SHOWN_ERRORS)
          $error("unexpected element %h at position %0d", e, p);
        return;
      end
      want = pending_elems.pop_front();
      if (e !== want.element) begin
        errors++;
        if (errors <= SHOWN_ERRORS)
          $error("element: expected %h, actual %h", want.element, e);
      end
      if (p !== want.position) begin
        errors++;
        if (errors <= SHOWN_ERRORS)
          $error("position: expected %0d, actual %0d", want.position, p);
      end
      if (l !== want.group_last) begin
        errors++;
        if (errors <= SHOWN_ERRORS)
          $error("group_last: expected %b, actual %b", want.group_last, l);
      end
    endfunction

    function int pending();
      return pending_elems.size();
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [scg_pkg::PADDR_W-1:0]  paddr = '0;
  logic [31:0]                  pwdata = '0;
  logic [31:0]                  prdata;
  logic                         pready;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         kind = scg_pkg::KIND_DATA;
  logic [scg_pkg::DATA_W-1:0]   value = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [scg_pkg::DATA_W-1:0]   element;
  logic [scg_pkg::POS_W-1:0]    position;
  logic                         group_last;

  int                  sender_idle = 0;
  int                  stall_pct = 0;
  int                  cycle_count = 0;
  chunk_scoreboard     sb = new();

  stream_chunk_grouper u_top (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .element    (element),
    .position   (position),
    .group_last (group_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.accept_item(kind, value);
    if (!rst && out_valid && out_ready) sb.check_element(element, position, group_last);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic apb_write(input logic [1:0] index, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(index, data);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_item(input logic k, input logic [scg_pkg::DATA_W-1:0] v);
    while ($urandom_range(0, 99) < sender_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    value <= v;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_regs(input logic [scg_pkg::GSIZE_W-1:0] gsize,
                          input logic [scg_pkg::MODE_W-1:0] mode,
                          input logic [scg_pkg::DATA_W-1:0] fillv);
    wait_idle();
    apb_write(scg_pkg::REG_GROUP_SIZE, 32'(gsize));
    apb_write(scg_pkg::REG_TAIL_MODE, 32'(mode));
    apb_write(scg_pkg::REG_FILL_VALUE, fillv);
  endtask

  task automatic run_phase(input logic [scg_pkg::GSIZE_W-1:0] gsize,
                           input logic [scg_pkg::MODE_W-1:0] mode,
                           input logic [scg_pkg::DATA_W-1:0] fillv, input int send_pct,
                           input int recv_pct);
    int unsigned eff;
    logic k;
    set_regs(gsize, mode, fillv);
    sender_idle = send_pct;
    stall_pct = recv_pct;
    eff = (gsize == 0) ? 1 :
          (gsize > scg_pkg::MAX_GROUP_DEF) ? scg_pkg::MAX_GROUP_DEF : gsize;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (n == PHASE_ITEMS / 2 || $urandom_range(0, 47) == 0) begin
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        @(negedge clk);
      end
      k = ($urandom_range(0, 2 * eff) == 0) ? scg_pkg::KIND_END : scg_pkg::KIND_DATA;
      send_item(k, $urandom);
    end
    send_item(scg_pkg::KIND_END, $urandom);
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: single-element groups, then an end marker on an empty buffer.
    send_item(scg_pkg::KIND_DATA, 32'h0000_0000);
    send_item(scg_pkg::KIND_DATA, 32'hFFFF_FFFF);
    send_item(scg_pkg::KIND_END, $urandom);

    // A zero group size behaves as one; an unmapped register is ignored.
    wait_idle();
    apb_write(scg_pkg::REG_GROUP_SIZE, 32'd0);
    apb_write(REG_UNMAPPED, $urandom);
    send_item(scg_pkg::KIND_DATA, $urandom);

    // An oversized group size is clamped, so the tail is padded to the maximum.
    set_regs(7'd127, scg_pkg::TAIL_PAD, 32'hFFFF_FFFF);
    send_item(scg_pkg::KIND_DATA, $urandom);
    send_item(scg_pkg::KIND_END, $urandom);

    // A full group, then a short tail.
    set_regs(7'd3, scg_pkg::TAIL_SHORT, $urandom);
    repeat (4) send_item(scg_pkg::KIND_DATA, $urandom);
    send_item(scg_pkg::KIND_END, $urandom);

    wait_idle();
    apb_write(scg_pkg::REG_FILL_VALUE, 32'h0000_0000);
    apb_write(scg_pkg::REG_TAIL_MODE, 32'(scg_pkg::TAIL_PAD));
    send_item(scg_pkg::KIND_DATA, $urandom);
    send_item(scg_pkg::KIND_END, $urandom);

    // Dropped tails, including the unused mode code.
    wait_idle();
    apb_write(scg_pkg::REG_TAIL_MODE, 32'(scg_pkg::TAIL_DROP));
    send_item(scg_pkg::KIND_DATA, $urandom);
    send_item(scg_pkg::KIND_END, $urandom);
    wait_idle();
    apb_write(scg_pkg::REG_TAIL_MODE, 32'(TAIL_UNUSED));
    send_item(scg_pkg::KIND_DATA, $urandom);
    send_item(scg_pkg::KIND_END, $urandom);

    // Group size lowered below the buffered count, closed by an end marker.
    set_regs(7'd5, scg_pkg::TAIL_DROP, $urandom);
    repeat (3) send_item(scg_pkg::KIND_DATA, $urandom);
    wait_idle();
    apb_write(scg_pkg::REG_GROUP_SIZE, 32'd2);
    send_item(scg_pkg::KIND_END, $urandom);

    // Group size lowered below the buffered count, closed by a data item.
    wait_idle();
    apb_write(scg_pkg::REG_GROUP_SIZE, 32'd5);
    repeat (3) send_item(scg_pkg::KIND_DATA, $urandom);
    wait_idle();
    apb_write(scg_pkg::REG_GROUP_SIZE, 32'd2);
    send_item(scg_pkg::KIND_DATA, $urandom);

    run_phase(7'd1, scg_pkg::TAIL_SHORT, 32'h0000_0000, 0, 0);
    run_phase(7'd64, scg_pkg::TAIL_PAD, 32'hFFFF_FFFF, 67, 0);
    run_phase(7'd5, scg_pkg::TAIL_DROP, $urandom, 0, 67);
    run_phase(7'd127, scg_pkg::TAIL_SHORT, $urandom, 32, 32);
    run_phase(7'd3, TAIL_UNUSED, $urandom, 0, 0);
    run_phase(7'd0, scg_pkg::TAIL_PAD, 32'h0000_0000, 67, 0);
    run_phase(7'($urandom_range(2, 16)), scg_pkg::TAIL_PAD, $urandom, 0, 67);
    run_phase(7'd8, scg_pkg::TAIL_SHORT, $urandom, 32, 32);

    wait_idle();
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
